// ----- design/hcb_pkg.sv -----
// Shared types and constants for the HSV color blob centroid block.
package hcb_pkg;

  localparam int NUM_W  = 49;
  localparam int DEN_W  = 33;
  localparam int Q_W    = 17;
  localparam int STEP_W = 6;
  localparam int CNT_W  = 21;
  localparam int SUM_W  = 31;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [Q_W-1:0]   Q14_ONE = 17'd16384;

  localparam logic [2:0] REG_STRIDE  = 3'd0;
  localparam logic [2:0] REG_HUE_MIN = 3'd1;
  localparam logic [2:0] REG_HUE_MAX = 3'd2;
  localparam logic [2:0] REG_SAT_MIN = 3'd3;
  localparam logic [2:0] REG_VAL_MIN = 3'd4;
  localparam logic [2:0] REG_FWIDTH  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PIX, S_COL, S_ROW, S_SAT, S_HUE, S_ACC,
    S_MUL, S_DIFF, S_AREA, S_CPOS, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_COL, OP_ROW, OP_SAT, OP_HUE, OP_AREA, OP_CPOS
  } op_t;

  typedef struct packed {
    logic load_px;
    logic div_start;
    op_t  div_op;
    logic acc;
    logic mul;
    logic diff;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic frame_end;
    logic out_free;
  } status_t;

endpackage

// ----- design/hcb_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module hcb_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hcb_pkg::NUM_W-1:0]    num,
  input  logic [hcb_pkg::DEN_W-1:0]    den,
  input  logic [hcb_pkg::STEP_W-1:0]   steps,
  output logic                         done,
  output logic [hcb_pkg::Q_W-1:0]      quo,
  output logic                         ovf,
  output logic [hcb_pkg::DEN_W-1:0]    rem
);

  logic [hcb_pkg::NUM_W-1:0]  num_r;
  logic [hcb_pkg::DEN_W-1:0]  den_r;
  logic [hcb_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [hcb_pkg::Q_W-1:0]    q_r;
  logic                       ovf_r;
  logic [hcb_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r, done_r;
  logic [hcb_pkg::DEN_W:0]    rem_sh, rem_sub;
  logic                       ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[hcb_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? rem_sub[hcb_pkg::DEN_W-1:0] : rem_sh[hcb_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == hcb_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= steps;
    end else if (busy_r) begin
      num_r <= {num_r[hcb_pkg::NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[hcb_pkg::Q_W-2:0], ge};
      ovf_r <= ovf_r | q_r[hcb_pkg::Q_W-1];
      cnt_r <= cnt_r - hcb_pkg::STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;
  assign rem  = rem_r;

endmodule

// ----- design/hcb_ctrl.sv -----
// Sequencing state machine for the HSV color blob centroid block.
module hcb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hcb_pkg::status_t sts,
  output hcb_pkg::cmd_t    cmd
);

  hcb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.div_op = hcb_pkg::OP_COL;
    case (state_r)
      hcb_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_px = 1'b1;
          state_nxt   = hcb_pkg::S_PIX;
        end
      end
      hcb_pkg::S_PIX: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = hcb_pkg::OP_COL;
        state_nxt     = hcb_pkg::S_COL;
      end
      hcb_pkg::S_COL: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = hcb_pkg::OP_ROW;
          state_nxt     = hcb_pkg::S_ROW;
        end
      end
      hcb_pkg::S_ROW: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = hcb_pkg::OP_SAT;
          state_nxt     = hcb_pkg::S_SAT;
        end
      end
      hcb_pkg::S_SAT: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = hcb_pkg::OP_HUE;
          state_nxt     = hcb_pkg::S_HUE;
        end
      end
      hcb_pkg::S_HUE: begin
        if (sts.div_done) begin
          state_nxt = hcb_pkg::S_ACC;
        end
      end
      hcb_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.frame_end ? hcb_pkg::S_MUL : hcb_pkg::S_IDLE;
      end
      hcb_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = hcb_pkg::S_DIFF;
      end
      hcb_pkg::S_DIFF: begin
        cmd.diff      = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_op    = hcb_pkg::OP_AREA;
        state_nxt     = hcb_pkg::S_AREA;
      end
      hcb_pkg::S_AREA: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = hcb_pkg::OP_CPOS;
          state_nxt     = hcb_pkg::S_CPOS;
        end
      end
      hcb_pkg::S_CPOS: begin
        if (sts.div_done) begin
          state_nxt = hcb_pkg::S_FIN;
        end
      end
      hcb_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = hcb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hcb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/hcb_dp.sv -----
// Datapath: settings, pixel latch, HSV terms, accumulators and result register.
module hcb_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [10:0]               cfg_data,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  input  logic [9:0]                in_column,
  input  logic [9:0]                in_row,
  input  logic                      in_frame_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_seen,
  output logic [20:0]               out_hit_total,
  output logic [20:0]               out_sample_total,
  output logic [16:0]               out_area_fraction,
  output logic signed [15:0]        out_centroid_pos,
  input  hcb_pkg::cmd_t             cmd,
  output hcb_pkg::status_t          sts
);

  logic [4:0]  stride_r;
  logic [7:0]  hue_min_r, hue_max_r, sat_min_r, val_min_r;
  logic [10:0] fwidth_r;

  logic [7:0]  red_r, green_r, blue_r;
  logic [9:0]  col_r, row_r;
  logic        fend_r;

  logic [hcb_pkg::CNT_W-1:0] hit_r, sample_r;
  logic [hcb_pkg::SUM_W-1:0] colsum_r;
  logic [31:0]               prod_r;
  logic [31:0]               abs_r;
  logic                      neg_r;

  logic        col_ok_r, row_ok_r;
  logic [7:0]  sat_r, hue_r;
  logic [16:0] area_r;
  logic [16:0] cq_r;
  logic        covf_r;
  hcb_pkg::op_t op_r;

  logic        out_valid_r;
  logic        seen_r;
  logic [20:0] hit_out_r, sample_out_r;
  logic [16:0] area_out_r;
  logic [15:0] cpos_out_r;

  logic [7:0]  mx, mn, dl;
  logic signed [17:0] rs, gs, bs, ds, hn;
  logic [16:0] hue_num, sat_num;
  logic [4:0]  stride_eff;

  logic [hcb_pkg::NUM_W-1:0]  div_num;
  logic [hcb_pkg::DEN_W-1:0]  div_den;
  logic [hcb_pkg::STEP_W-1:0] div_steps;
  logic                       div_done, div_ovf;
  logic [hcb_pkg::Q_W-1:0]    div_q;
  logic [hcb_pkg::DEN_W-1:0]  div_rem;

  logic        sampled, hit;
  logic [31:0] colsum_add;
  logic [31:0] prod_nxt;
  logic [33:0] diff34, neg34;
  logic [16:0] cmag;
  logic [15:0] cpos_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r  <= 5'd4;
      hue_min_r <= 8'd35;
      hue_max_r <= 8'd85;
      sat_min_r <= 8'd80;
      val_min_r <= 8'd50;
      fwidth_r  <= 11'd320;
    end else if (cfg_we) begin
      case (cfg_index)
        hcb_pkg::REG_STRIDE:  stride_r  <= cfg_data[4:0];
        hcb_pkg::REG_HUE_MIN: hue_min_r <= cfg_data[7:0];
        hcb_pkg::REG_HUE_MAX: hue_max_r <= cfg_data[7:0];
        hcb_pkg::REG_SAT_MIN: sat_min_r <= cfg_data[7:0];
        hcb_pkg::REG_VAL_MIN: val_min_r <= cfg_data[7:0];
        hcb_pkg::REG_FWIDTH:  fwidth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      col_r   <= in_column;
      row_r   <= in_row;
      fend_r  <= in_frame_end;
    end
  end

  // HSV terms from the latched pixel.
  always_comb begin
    mx = red_r;
    if (green_r > mx) mx = green_r;
    if (blue_r > mx)  mx = blue_r;
    mn = red_r;
    if (green_r < mn) mn = green_r;
    if (blue_r < mn)  mn = blue_r;
    dl = mx - mn;
    rs = $signed({10'b0, red_r});
    gs = $signed({10'b0, green_r});
    bs = $signed({10'b0, blue_r});
    ds = $signed({10'b0, dl});
    if (mx == red_r) begin
      hn = 18'sd30 * (gs - bs);
      if (gs < bs) hn = hn + 18'sd180 * ds;
    end else if (mx == green_r) begin
      hn = 18'sd30 * (bs - rs) + 18'sd60 * ds;
    end else begin
      hn = 18'sd30 * (rs - gs) + 18'sd120 * ds;
    end
    hue_num = {hn[15:0], 1'b0} + {9'b0, dl};
    sat_num = 17'({9'b0, dl} * 17'd510) + {9'b0, mx};
    stride_eff = (stride_r == 5'd0) ? 5'd1 : stride_r;
  end

  // Divider operand selection, numerator left-aligned except for the centroid division.
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    case (cmd.div_op)
      hcb_pkg::OP_COL: begin
        div_num   = {col_r, 39'b0};
        div_den   = {28'b0, stride_eff};
        div_steps = 6'd10;
      end
      hcb_pkg::OP_ROW: begin
        div_num   = {row_r, 39'b0};
        div_den   = {28'b0, stride_eff};
        div_steps = 6'd10;
      end
      hcb_pkg::OP_SAT: begin
        div_num   = {sat_num, 32'b0};
        div_den   = {24'b0, mx, 1'b0};
        div_steps = 6'd17;
      end
      hcb_pkg::OP_HUE: begin
        div_num   = {hue_num, 32'b0};
        div_den   = {24'b0, dl, 1'b0};
        div_steps = 6'd17;
      end
      hcb_pkg::OP_AREA: begin
        div_num   = {hit_r, 28'b0};
        div_den   = {12'b0, sample_r};
        div_steps = 6'd37;
      end
      hcb_pkg::OP_CPOS: begin
        div_num   = {2'b0, abs_r, 15'b0} + {17'b0, prod_r};
        div_den   = {prod_r, 1'b0};
        div_steps = 6'd49;
      end
      default: ;
    endcase
  end

  hcb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_q),
    .ovf   (div_ovf),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) op_r <= cmd.div_op;
    if (div_done) begin
      case (op_r)
        hcb_pkg::OP_COL:  col_ok_r <= (div_rem == '0);
        hcb_pkg::OP_ROW:  row_ok_r <= (div_rem == '0);
        hcb_pkg::OP_SAT:  sat_r    <= (mx == 8'd0) ? 8'd0 : div_q[7:0];
        hcb_pkg::OP_HUE:  hue_r    <= (dl == 8'd0) ? 8'd0 : div_q[7:0];
        hcb_pkg::OP_AREA: area_r   <= (sample_r == '0) ? 17'd0 : div_q;
        hcb_pkg::OP_CPOS: begin
          cq_r   <= div_q;
          covf_r <= div_ovf;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sampled    = col_ok_r & row_ok_r;
    hit        = sampled && (hue_r >= hue_min_r) && (hue_r <= hue_max_r) &&
                 (sat_r >= sat_min_r) && (mx >= val_min_r);
    colsum_add = {1'b0, colsum_r} + {22'b0, col_r};
    prod_nxt   = {21'b0, fwidth_r} * {11'b0, hit_r};
    diff34     = {2'b0, colsum_r, 1'b0} - {2'b0, prod_r};
    neg34      = 34'd0 - diff34;
    cmag       = (covf_r || cq_r > hcb_pkg::Q14_ONE) ? hcb_pkg::Q14_ONE : cq_r;
    if (hit_r == '0 || fwidth_r == 11'd0) begin
      cpos_nxt = 16'd0;
    end else begin
      cpos_nxt = neg_r ? (16'd0 - cmag[15:0]) : cmag[15:0];
    end
  end

  // Frame accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r    <= '0;
      sample_r <= '0;
      colsum_r <= '0;
    end else if (cmd.res_load) begin
      hit_r    <= '0;
      sample_r <= '0;
      colsum_r <= '0;
    end else if (cmd.acc && sampled) begin
      if (sample_r != hcb_pkg::CNT_MAX) sample_r <= sample_r + 21'd1;
      if (hit) begin
        if (hit_r != hcb_pkg::CNT_MAX) hit_r <= hit_r + 21'd1;
        colsum_r <= colsum_add[31] ? hcb_pkg::SUM_MAX : colsum_add[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= prod_nxt;
    if (cmd.diff) begin
      neg_r <= diff34[33];
      abs_r <= diff34[33] ? neg34[31:0] : diff34[31:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      seen_r       <= (hit_r != '0);
      hit_out_r    <= hit_r;
      sample_out_r <= sample_r;
      area_out_r   <= area_r;
      cpos_out_r   <= cpos_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seen          = seen_r;
  assign out_hit_total     = hit_out_r;
  assign out_sample_total  = sample_out_r;
  assign out_area_fraction = area_out_r;
  assign out_centroid_pos  = $signed(cpos_out_r);

  assign sts.div_done  = div_done;
  assign sts.frame_end = fend_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

// ----- design/hsv_color_blob_centroid.sv -----
// Top level of the HSV color window blob centroid block.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | red, green, blue, column, row, frame_end
//   out     | output    | out_valid / out_stall| seen, totals, area_fraction, centroid_pos
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One request is taken at a time. Each pixel makes four passes of the
// shared serial divider (stride tests on column and row, then saturation
// and hue) plus setup and accumulate steps. A frame-end pixel adds the
// area and centroid divisions. Reset is synchronous and active low; it loads
// register defaults and clears the accumulators. The result waits in an
// output register, so a stalled result blocks only the next frame-end, not
// ordinary pixels.
module hsv_color_blob_centroid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [9:0]         in_column,
  input  logic [9:0]         in_row,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_seen,
  output logic [20:0]        out_hit_total,
  output logic [20:0]        out_sample_total,
  output logic [16:0]        out_area_fraction,
  output logic signed [15:0] out_centroid_pos
);

  // Command and status between the sequencer and the datapath.
  hcb_pkg::cmd_t    cmd;
  hcb_pkg::status_t sts;

  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_seen          (out_seen),
    .out_hit_total     (out_hit_total),
    .out_sample_total  (out_sample_total),
    .out_area_fraction (out_area_fraction),
    .out_centroid_pos  (out_centroid_pos),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ----- design/hcb_checker.sv -----
// Port-level checker for the HSV color blob centroid block, with its bind.
module hcb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_seen,
  input logic [20:0]        out_hit_total,
  input logic [20:0]        out_sample_total,
  input logic [16:0]        out_area_fraction,
  input logic signed [15:0] out_centroid_pos
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_total) &&
      $stable(out_centroid_pos))
    else $error("stalled result changed");

  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seen == (out_hit_total != 21'd0))
    else $error("seen flag disagrees with hit total");

  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_total <= out_sample_total)
    else $error("more hits than samples");

  a_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_area_fraction <= 17'd65536)
    else $error("area fraction above one");

  a_cpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_centroid_pos <= 16'sd16384 && out_centroid_pos >= -16'sd16384)
    else $error("centroid outside unit range");

endmodule

bind hsv_color_blob_centroid hcb_checker u_hcb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_seen          (out_seen),
  .out_hit_total     (out_hit_total),
  .out_sample_total  (out_sample_total),
  .out_area_fraction (out_area_fraction),
  .out_centroid_pos  (out_centroid_pos)
);
